[rtl/core/bemn_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the button event menu navigator.
// Used by the interfaces, the cursor unit and the top level; depends on nothing.
package bemn_pkg;

	localparam int BUTTON_COUNT = 8;
	// At most buttons 0 to 7 are walked, however many buttons there are.
	localparam int WALK_COUNT = (BUTTON_COUNT > 8) ? 8 : BUTTON_COUNT;
	localparam int BTN_W = 3;
	localparam logic [BTN_W-1:0] WALK_LAST = BTN_W'(WALK_COUNT - 1);

	localparam int LEVELS_W = 8;
	localparam int ITEM_W = 8;
	localparam int TICKS_W = 16;
	localparam int ROWS_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MENU_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_BUTTON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_BUTTON = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_BUTTON = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_BUTTON = 3'd6;

	localparam logic [1:0] KIND_PRESSED = 2'd0;
	localparam logic [1:0] KIND_RELEASED = 2'd1;
	localparam logic [1:0] KIND_HELD = 2'd2;

	localparam logic [1:0] ROUTE_SCREEN = 2'd0;
	localparam logic [1:0] ROUTE_MENU = 2'd1;
	localparam logic [1:0] ROUTE_TOGGLED = 2'd2;
	localparam logic [1:0] ROUTE_SUPPRESSED = 2'd3;

	typedef struct packed {
		logic [BTN_W-1:0]  button;
		logic [1:0]        event_kind;
		logic [1:0]        route;
		logic              menu_open;
		logic [ITEM_W-1:0] cursor;
		logic [ITEM_W-1:0] window_top;
		logic              activated;
		logic              last;
	} event_t;

	typedef struct packed {
		logic [ITEM_W-1:0] cursor;
		logic [ITEM_W-1:0] top;
		logic [ITEM_W-1:0] length;
		logic [ROWS_W-1:0] rows;
		logic              move_up;
	} cur_req_t;

	typedef struct packed {
		logic [ITEM_W-1:0] cursor;
		logic [ITEM_W-1:0] top;
	} cur_rsp_t;

endpackage

[rtl/core/bemn_poll_if.sv]
`timescale 1ns / 1ps
// Input channel: one beat carries one poll of the button levels.
// Depends on bemn_pkg for the field width.
interface bemn_poll_if;
	logic                           valid;
	logic                           ready;
	logic [bemn_pkg::LEVELS_W-1:0]  button_levels;

	modport source (output valid, output button_levels, input ready);
	modport sink (input valid, input button_levels, output ready);
endinterface

[rtl/core/bemn_event_if.sv]
`timescale 1ns / 1ps
// Output channel: one beat carries one button event and the menu state after it.
// Depends on bemn_pkg for the field widths.
interface bemn_event_if;
	logic                         valid;
	logic                         ready;
	logic [bemn_pkg::BTN_W-1:0]   button;
	logic [1:0]                   event_kind;
	logic [1:0]                   route;
	logic                         menu_open;
	logic [bemn_pkg::ITEM_W-1:0]  cursor;
	logic [bemn_pkg::ITEM_W-1:0]  window_top;
	logic                         activated;
	logic                         last;

	modport source (output valid, output button, output event_kind, output route,
		output menu_open, output cursor, output window_top, output activated,
		output last, input ready);
	modport sink (input valid, input button, input event_kind, input route,
		input menu_open, input cursor, input window_top, input activated,
		input last, output ready);
endinterface

[rtl/core/bemn_cursor_unit.sv]
`timescale 1ns / 1ps
// Shared cursor step unit: moves the cursor one item up or down with wrap and
// scrolls the window so the cursor stays visible. Depends on bemn_pkg.
module bemn_cursor_unit (
	input  bemn_pkg::cur_req_t req,
	output bemn_pkg::cur_rsp_t rsp
);

	logic [bemn_pkg::ROWS_W-1:0] rows;
	logic [bemn_pkg::ITEM_W-1:0] next_cur;
	logic [bemn_pkg::ITEM_W:0]   cur_inc;
	logic [bemn_pkg::ITEM_W:0]   win_end;
	logic [bemn_pkg::ITEM_W-1:0] top_a;

	assign rows = (req.rows == '0) ? bemn_pkg::ROWS_W'(1) : req.rows;
	assign cur_inc = {1'b0, req.cursor} + 9'd1;

	always_comb begin
		if (req.move_up) begin
			next_cur = (req.cursor == '0) ? req.length - 8'd1 : req.cursor - 8'd1;
		end else begin
			next_cur = (cur_inc == {1'b0, req.length}) ? '0 : cur_inc[7:0];
		end
	end

	assign win_end = {1'b0, req.top} + {4'b0, rows};

	always_comb begin
		// The cursor is at least one window below the top here, so no underflow.
		if ({1'b0, next_cur} >= win_end) begin
			top_a = next_cur - {3'b0, rows} + 8'd1;
		end else begin
			top_a = req.top;
		end
		rsp.cursor = next_cur;
		rsp.top = (next_cur < top_a) ? next_cur : top_a;
	end

endmodule

[rtl/core/button_event_menu_navigator.sv]
`timescale 1ns / 1ps
// Button event menu navigator: turns polls of the button levels into press,
// release and hold events and drives a scrolling menu cursor.
// Depends on bemn_pkg, bemn_poll_if, bemn_event_if and bemn_cursor_unit.
//
// Usage: the poll channel takes one beat per sample of the button levels. For
// each poll the block walks the buttons in index order, one button per cycle
// while a button gives no event, and sends one event beat for every button
// that was pressed, released or reached its hold count; the final event of a
// poll has last set, and a poll without events sends nothing. A press or hold
// routed to a non-empty menu passes through the shared cursor unit (up step,
// then down step and center), and every event is queued in the emit state.
// The poll channel is not ready while a poll is being walked.
// One event waits in a pending register until the walk knows whether it is the
// last one, and one sits in the output register. When the receiver stalls, the
// walk stops at the next event until the output register frees up.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user
// only while idle (not enforced by the block); a menu length write also resets
// the cursor and closes the menu. Reset clears all hold counts, the previous
// levels and the menu state, and loads the register reset values.
module button_event_menu_navigator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bemn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bemn_pkg::CFG_DATA_W-1:0]    cfg_data,
	bemn_poll_if.sink                          poll,
	bemn_event_if.source                       events
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_UP = 3'd2;
	localparam logic [2:0] S_DOWN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	// Configuration registers.
	logic [bemn_pkg::ITEM_W-1:0]  menu_len_q;
	logic [bemn_pkg::TICKS_W-1:0] hold_ticks_q;
	logic [bemn_pkg::ROWS_W-1:0]  vis_rows_q;
	logic [bemn_pkg::BTN_W-1:0]   step_btn_q;
	logic [bemn_pkg::BTN_W-1:0]   up_btn_q;
	logic [bemn_pkg::BTN_W-1:0]   down_btn_q;
	logic [bemn_pkg::BTN_W-1:0]   center_btn_q;

	// Walk and menu state.
	logic [2:0]                    state_q;
	logic [bemn_pkg::BTN_W-1:0]    idx_q;
	logic [bemn_pkg::LEVELS_W-1:0] levels_q;
	logic [bemn_pkg::LEVELS_W-1:0] prev_q;
	logic [bemn_pkg::TICKS_W-1:0]  hold_q [bemn_pkg::WALK_COUNT];
	logic                          menu_vis_q;
	logic                          open_press_q;
	logic [bemn_pkg::ITEM_W-1:0]   cursor_q;
	logic [bemn_pkg::ITEM_W-1:0]   top_q;

	// Event being built.
	logic [1:0] kind_q;
	logic [1:0] route_q;
	logic       act_q;

	logic              pend_valid_q;
	bemn_pkg::event_t  pend_q;
	logic              out_valid_q;
	bemn_pkg::event_t  out_q;

	// Evaluation of the button under the walk.
	logic                         down;
	logic                         changed;
	logic [bemn_pkg::TICKS_W-1:0] cnt_inc;
	logic                         hold_hit;
	logic                         toggle;
	logic                         open_next;
	logic                         at_last;
	logic                         out_free;
	logic                         out_load;

	bemn_pkg::cur_req_t cur_req;
	bemn_pkg::cur_rsp_t cur_rsp;
	bemn_pkg::event_t   new_evt;
	bemn_pkg::event_t   pend_last;

	assign down = levels_q[idx_q];
	assign changed = down ^ prev_q[idx_q];
	assign cnt_inc = hold_q[idx_q] + 16'd1;
	assign hold_hit = cnt_inc >= hold_ticks_q;
	assign toggle = (idx_q == step_btn_q) && down && (menu_len_q != '0);
	assign open_next = down ? menu_vis_q : open_press_q;
	assign at_last = idx_q == bemn_pkg::WALK_LAST;
	assign out_free = !out_valid_q || events.ready;
	// The pending beat moves into the output register in this cycle.
	assign out_load = (state_q == S_EMIT || state_q == S_FLUSH) && pend_valid_q && out_free;

	assign cur_req.cursor = cursor_q;
	assign cur_req.top = top_q;
	assign cur_req.length = menu_len_q;
	assign cur_req.rows = vis_rows_q;
	assign cur_req.move_up = state_q == S_UP;

	bemn_cursor_unit u_cursor (
		.req(cur_req),
		.rsp(cur_rsp)
	);

	always_comb begin
		new_evt.button = idx_q;
		new_evt.event_kind = kind_q;
		new_evt.route = route_q;
		new_evt.menu_open = menu_vis_q;
		new_evt.cursor = cursor_q;
		new_evt.window_top = top_q;
		new_evt.activated = act_q;
		new_evt.last = 1'b0;
	end

	always_comb begin
		pend_last = pend_q;
		pend_last.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_len_q <= '0;
			hold_ticks_q <= 16'd50;
			vis_rows_q <= 5'd5;
			step_btn_q <= 3'd0;
			up_btn_q <= 3'd1;
			down_btn_q <= 3'd2;
			center_btn_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				bemn_pkg::REG_MENU_LENGTH: menu_len_q <= cfg_data[7:0];
				bemn_pkg::REG_HOLD_TICKS: hold_ticks_q <= cfg_data;
				bemn_pkg::REG_VISIBLE_ROWS: vis_rows_q <= cfg_data[4:0];
				bemn_pkg::REG_STEP_BUTTON: step_btn_q <= cfg_data[2:0];
				bemn_pkg::REG_UP_BUTTON: up_btn_q <= cfg_data[2:0];
				bemn_pkg::REG_DOWN_BUTTON: down_btn_q <= cfg_data[2:0];
				bemn_pkg::REG_CENTER_BUTTON: center_btn_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			prev_q <= '0;
			for (int i = 0; i < bemn_pkg::WALK_COUNT; i++) begin
				hold_q[i] <= '0;
			end
			menu_vis_q <= 1'b0;
			open_press_q <= 1'b0;
			cursor_q <= '0;
			top_q <= '0;
			kind_q <= '0;
			route_q <= '0;
			act_q <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (events.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (poll.valid) begin
						idx_q <= '0;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					act_q <= 1'b0;
					if (changed) begin
						hold_q[idx_q] <= '0;
						kind_q <= down ? bemn_pkg::KIND_PRESSED : bemn_pkg::KIND_RELEASED;
						if (toggle) begin
							menu_vis_q <= !menu_vis_q;
							route_q <= bemn_pkg::ROUTE_TOGGLED;
							state_q <= S_EMIT;
						end else begin
							open_press_q <= open_next;
							if (menu_vis_q) begin
								route_q <= bemn_pkg::ROUTE_MENU;
								// Releases reach the menu but move nothing.
								state_q <= (down && menu_len_q != '0) ? S_UP : S_EMIT;
							end else begin
								route_q <= open_next ? bemn_pkg::ROUTE_SUPPRESSED
									: bemn_pkg::ROUTE_SCREEN;
								state_q <= S_EMIT;
							end
						end
					end else if (down && hold_hit) begin
						hold_q[idx_q] <= '0;
						kind_q <= bemn_pkg::KIND_HELD;
						if (menu_vis_q) begin
							route_q <= bemn_pkg::ROUTE_MENU;
							state_q <= (menu_len_q != '0) ? S_UP : S_EMIT;
						end else begin
							route_q <= bemn_pkg::ROUTE_SCREEN;
							state_q <= S_EMIT;
						end
					end else begin
						if (down) begin
							hold_q[idx_q] <= cnt_inc;
						end
						if (at_last) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				S_UP: begin
					if (idx_q == up_btn_q) begin
						cursor_q <= cur_rsp.cursor;
						top_q <= cur_rsp.top;
					end
					state_q <= S_DOWN;
				end
				S_DOWN: begin
					if (idx_q == down_btn_q) begin
						cursor_q <= cur_rsp.cursor;
						top_q <= cur_rsp.top;
					end
					if (idx_q == center_btn_q) begin
						act_q <= 1'b1;
						menu_vis_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// The pending event is known not to be last once a newer one exists.
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_q <= pend_q;
							out_valid_q <= 1'b1;
						end
						pend_q <= new_evt;
						pend_valid_q <= 1'b1;
						if (at_last) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= S_EVAL;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						prev_q <= levels_q;
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q <= pend_last;
						out_valid_q <= 1'b1;
						pend_valid_q <= 1'b0;
						prev_q <= levels_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we && cfg_index == bemn_pkg::REG_MENU_LENGTH) begin
				cursor_q <= '0;
				menu_vis_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && poll.valid) begin
			levels_q <= poll.button_levels;
		end
	end

	assign poll.ready = state_q == S_IDLE;

	assign events.valid = out_valid_q;
	assign events.button = out_q.button;
	assign events.event_kind = out_q.event_kind;
	assign events.route = out_q.route;
	assign events.menu_open = out_q.menu_open;
	assign events.cursor = out_q.cursor;
	assign events.window_top = out_q.window_top;
	assign events.activated = out_q.activated;
	assign events.last = out_q.last;

	// A finished walk leaves nothing pending.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("event left pending while idle");

	// The cursor stays inside a non-empty menu.
	a_cursor_in_menu: assert property (@(posedge clk) disable iff (!arst_n)
		menu_len_q != '0 |-> cursor_q < menu_len_q)
		else $error("cursor beyond menu length");

	// Only a press toggles the menu.
	a_toggle_is_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.route == bemn_pkg::ROUTE_TOGGLED
		|-> out_q.event_kind == bemn_pkg::KIND_PRESSED)
		else $error("menu toggled by a non-press event");

	// An activation comes from the menu and closes it.
	a_activate_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.activated
		|-> !out_q.menu_open && out_q.route == bemn_pkg::ROUTE_MENU)
		else $error("activation outside the menu");

	// The up step is always followed by the down step.
	a_up_then_down: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UP |=> state_q == S_DOWN)
		else $error("cursor sequence broken");

endmodule

[tb/tb_button_event_menu_navigator.sv]
`timescale 1ns / 1ps
// Self-checking testbench of button_event_menu_navigator: drives polls of the button levels,
// predicts every event beat with its own copy of the menu state and checks each one.
// Depends on bemn_pkg, bemn_poll_if, bemn_event_if and the block itself.
module tb_button_event_menu_navigator;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_POLLS = 43;
	localparam int SQUEEZE_AT = 120;
	localparam int HOLD_OFF = 300;
	localparam int PHASES = 7;
	localparam int LEN_PICK [PHASES] = '{1, 255, 6, 0, 12, 200, 3};
	localparam int HOLD_PICK [PHASES] = '{1, 65535, 0, 3, 2, 4, 50};
	localparam int ROWS_PICK [PHASES] = '{1, 16, 0, 31, 5, 3, 2};

	// Tracks the menu state and keeps the event beats still to come, oldest first.
	class nav_tracker;
		bit [7:0] menu_len;
		bit [15:0] hold_lim;
		bit [4:0] rows_cfg;
		bit [2:0] step_btn, up_btn, down_btn, center_btn;
		bit [7:0] prev_lv;
		bit [15:0] held_for [8];
		bit shown, began_shown;
		bit [7:0] cur, top;
		bemn_pkg::event_t due_events [$];
		int errors;

		function new();
			menu_len = 0;
			hold_lim = 50;
			rows_cfg = 5;
			step_btn = 0;
			up_btn = 1;
			down_btn = 2;
			center_btn = 3;
			prev_lv = 0;
			foreach (held_for[i]) held_for[i] = 0;
			shown = 0;
			began_shown = 0;
			cur = 0;
			top = 0;
			errors = 0;
		endfunction

		function void configure(bit [bemn_pkg::CFG_IDX_W-1:0] idx, bit [15:0] val);
			case (idx)
				bemn_pkg::REG_MENU_LENGTH: begin
					menu_len = val[7:0];
					cur = 0;
					shown = 0;
				end
				bemn_pkg::REG_HOLD_TICKS: hold_lim = val;
				bemn_pkg::REG_VISIBLE_ROWS: rows_cfg = val[4:0];
				bemn_pkg::REG_STEP_BUTTON: step_btn = val[2:0];
				bemn_pkg::REG_UP_BUTTON: up_btn = val[2:0];
				bemn_pkg::REG_DOWN_BUTTON: down_btn = val[2:0];
				bemn_pkg::REG_CENTER_BUTTON: center_btn = val[2:0];
				default: ;
			endcase
		endfunction

		function void fit_window();
			int rows;
			rows = (rows_cfg != 0) ? int'(rows_cfg) : 1;
			if (int'(cur) >= int'(top) + rows) top = 8'(int'(cur) - rows + 1);
			if (cur < top) top = cur;
		endfunction

		// Up, down and center are tried in that order, so shared indices all act.
		function bit menu_act(int b, bit [1:0] kind);
			bit act;
			act = 0;
			if (kind == bemn_pkg::KIND_RELEASED || menu_len == 0) return 0;
			if (b == int'(up_btn)) begin
				cur = (cur > 0) ? cur - 8'd1 : menu_len - 8'd1;
				fit_window();
			end
			if (b == int'(down_btn)) begin
				cur = 8'((int'(cur) + 1) % int'(menu_len));
				fit_window();
			end
			if (b == int'(center_btn)) begin
				act = 1;
				shown = 0;
			end
			return act;
		endfunction

		function void take_poll(bit [7:0] lv);
			bit [7:0] flips;
			bit [1:0] kind, route;
			bit act, fire, have_ev;
			bemn_pkg::event_t ev, held_ev;
			flips = lv ^ prev_lv;
			have_ev = 0;
			for (int i = 0; i < bemn_pkg::WALK_COUNT; i++) begin
				act = 0;
				fire = 1;
				kind = bemn_pkg::KIND_PRESSED;
				route = bemn_pkg::ROUTE_SCREEN;
				if (flips[i]) begin
					held_for[i] = 0;
					kind = lv[i] ? bemn_pkg::KIND_PRESSED : bemn_pkg::KIND_RELEASED;
					if (i == int'(step_btn) && lv[i] && menu_len != 0) begin
						shown = !shown;
						route = bemn_pkg::ROUTE_TOGGLED;
					end else begin
						if (lv[i]) began_shown = shown;
						if (shown) begin
							route = bemn_pkg::ROUTE_MENU;
							act = menu_act(i, kind);
						end else
							route = began_shown ? bemn_pkg::ROUTE_SUPPRESSED
								: bemn_pkg::ROUTE_SCREEN;
					end
				end else if (lv[i]) begin
					held_for[i]++;
					if (held_for[i] < hold_lim)
						fire = 0;
					else begin
						held_for[i] = 0;
						kind = bemn_pkg::KIND_HELD;
						if (shown) begin
							route = bemn_pkg::ROUTE_MENU;
							act = menu_act(i, kind);
						end else
							route = bemn_pkg::ROUTE_SCREEN;
					end
				end else
					fire = 0;
				if (fire) begin
					// The previous event is known not to be the last one now.
					if (have_ev) due_events.push_back(held_ev);
					ev.button = 3'(i);
					ev.event_kind = kind;
					ev.route = route;
					ev.menu_open = shown;
					ev.cursor = cur;
					ev.window_top = top;
					ev.activated = act;
					ev.last = 0;
					held_ev = ev;
					have_ev = 1;
				end
			end
			if (have_ev) begin
				held_ev.last = 1;
				due_events.push_back(held_ev);
			end
			prev_lv = lv;
		endfunction

		function void cmp(string what, bit [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_event(bemn_pkg::event_t got);
			bemn_pkg::event_t want;
			if (due_events.size() == 0) begin
				$display("%0t ns: event beat expected none got button %0h kind %0h route %0h",
					$time, got.button, got.event_kind, got.route);
				errors++;
				return;
			end
			want = due_events.pop_front();
			cmp("button", 8'(want.button), 8'(got.button));
			cmp("event_kind", 8'(want.event_kind), 8'(got.event_kind));
			cmp("route", 8'(want.route), 8'(got.route));
			cmp("menu_open", 8'(want.menu_open), 8'(got.menu_open));
			cmp("cursor", want.cursor, got.cursor);
			cmp("window_top", want.window_top, got.window_top);
			cmp("activated", 8'(want.activated), 8'(got.activated));
			cmp("last", 8'(want.last), 8'(got.last));
		endfunction

		function int pending();
			return due_events.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bemn_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bemn_pkg::CFG_DATA_W-1:0] cfg_data;

	bemn_poll_if poll_ch ();
	bemn_event_if event_ch ();

	button_event_menu_navigator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.poll(poll_ch.sink),
		.events(event_ch.source)
	);

	nav_tracker book;
	bit calm;
	bit squeeze_req;
	int polls_taken;
	int quiet;
	bemn_pkg::event_t seen_ev;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers one poll; returns at the falling edge after its beat was taken.
	task automatic send_poll(input bit [7:0] lv);
		while (!calm && $urandom_range(0, 99) < 25) begin
			poll_ch.valid <= 1'b0;
			@(negedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.button_levels <= lv;
		do @(posedge clk); while (poll_ch.ready !== 1'b1);
		book.take_poll(lv);
		polls_taken++;
		if (polls_taken == SQUEEZE_AT) squeeze_req = 1;
		@(negedge clk);
	endtask

	// Stops offering polls and waits until the block has drained.
	task automatic settle();
		poll_ch.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bemn_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bemn_pkg::CFG_DATA_W'(val);
		book.configure(idx, 16'(val));
		@(negedge clk);
	endtask

	// Mostly single-button changes on the menu buttons, some holds and some noise.
	function automatic bit [7:0] next_levels(bit [7:0] now_lv);
		int r;
		int b;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'($urandom);
		if (r < 14) return 8'h00;
		if (r < 36) return now_lv;
		case ($urandom_range(0, 5))
			0: b = int'(book.step_btn);
			1: b = int'(book.up_btn);
			2: b = int'(book.down_btn);
			3: b = int'(book.center_btn);
			default: b = $urandom_range(0, 7);
		endcase
		return now_lv ^ (8'h01 << b);
	endfunction

	initial begin
		event_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				// Long stall so that the block fills up and stops taking polls.
				squeeze_req = 0;
				event_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end else
				event_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
			seen_ev.button = event_ch.button;
			seen_ev.event_kind = event_ch.event_kind;
			seen_ev.route = event_ch.route;
			seen_ev.menu_open = event_ch.menu_open;
			seen_ev.cursor = event_ch.cursor;
			seen_ev.window_top = event_ch.window_top;
			seen_ev.activated = event_ch.activated;
			seen_ev.last = event_ch.last;
			book.check_event(seen_ev);
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((poll_ch.valid === 1'b1 && poll_ch.ready === 1'b1) ||
				(event_ch.valid === 1'b1 && event_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_button_event_menu_navigator NOT OK");
		$finish;
	end

	initial begin
		bit [7:0] lv;
		book = new();
		calm = 0;
		squeeze_req = 0;
		polls_taken = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bemn_pkg::REG_MENU_LENGTH;
		cfg_data <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.button_levels <= '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings, empty menu: the step button only reaches the screen.
		send_poll(8'hFF);
		send_poll(8'hFF);
		send_poll(8'h00);
		send_poll(8'h01);
		send_poll(8'h00);
		settle();

		// Short menu, a held event on every poll that keeps a button down and zero rows taken as one.
		write_reg(bemn_pkg::REG_MENU_LENGTH, 3);
		write_reg(bemn_pkg::REG_HOLD_TICKS, 0);
		write_reg(bemn_pkg::REG_VISIBLE_ROWS, 0);
		write_reg(bemn_pkg::REG_STEP_BUTTON, 0);
		write_reg(bemn_pkg::REG_UP_BUTTON, 1);
		write_reg(bemn_pkg::REG_DOWN_BUTTON, 2);
		write_reg(bemn_pkg::REG_CENTER_BUTTON, 3);
		cfg_we <= 1'b0;
		send_poll(8'h01);
		send_poll(8'h00);
		send_poll(8'h02);
		send_poll(8'h00);
		send_poll(8'h04);
		send_poll(8'h04);
		send_poll(8'h00);
		send_poll(8'h10);
		send_poll(8'h00);
		send_poll(8'h08);
		send_poll(8'h00);
		send_poll(8'h20);
		settle();

		// Full menu with up, down and center on one button.
		write_reg(bemn_pkg::REG_MENU_LENGTH, 255);
		write_reg(bemn_pkg::REG_HOLD_TICKS, 65535);
		write_reg(bemn_pkg::REG_VISIBLE_ROWS, 16);
		write_reg(bemn_pkg::REG_STEP_BUTTON, 7);
		write_reg(bemn_pkg::REG_UP_BUTTON, 5);
		write_reg(bemn_pkg::REG_DOWN_BUTTON, 5);
		write_reg(bemn_pkg::REG_CENTER_BUTTON, 5);
		cfg_we <= 1'b0;
		send_poll(8'h80);
		send_poll(8'hA0);
		send_poll(8'h00);
		send_poll(8'h80);
		send_poll(8'h00);
		send_poll(8'h80);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			@(posedge clk);
			calm = (ph == 2);
			@(negedge clk);
			write_reg(bemn_pkg::REG_MENU_LENGTH, LEN_PICK[ph]);
			write_reg(bemn_pkg::REG_HOLD_TICKS, HOLD_PICK[ph]);
			write_reg(bemn_pkg::REG_VISIBLE_ROWS, ROWS_PICK[ph]);
			write_reg(bemn_pkg::REG_STEP_BUTTON, $urandom_range(0, 7));
			write_reg(bemn_pkg::REG_UP_BUTTON, $urandom_range(0, 7));
			write_reg(bemn_pkg::REG_DOWN_BUTTON, $urandom_range(0, 7));
			write_reg(bemn_pkg::REG_CENTER_BUTTON, $urandom_range(0, 7));
			cfg_we <= 1'b0;
			lv = book.prev_lv;
			repeat (PHASE_POLLS) begin
				lv = next_levels(lv);
				send_poll(lv);
			end
		end
		settle();

		if (book.errors == 0)
			$display("tb_button_event_menu_navigator OK");
		else
			$display("tb_button_event_menu_navigator NOT OK");
		$finish;
	end

endmodule

[button_event_menu_navigator.f]
rtl/core/bemn_pkg.sv
rtl/core/bemn_poll_if.sv
rtl/core/bemn_event_if.sv
rtl/core/bemn_cursor_unit.sv
rtl/core/button_event_menu_navigator.sv
tb/tb_button_event_menu_navigator.sv
